// ----- hdl/delimited_packet_deframer_top_defines.svh -----
// Assertion macros shared by the deframer checker.
`ifndef DELIMITED_PACKET_DEFRAMER_TOP_DEFINES_SVH
`define DELIMITED_PACKET_DEFRAMER_TOP_DEFINES_SVH

// Checks a property on every rising clock edge outside of reset.
`define DPD_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("deframer check failed");

// Checks that the consequent holds in the cycle after the antecedent.
`define DPD_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("deframer check failed");

`endif

// ----- hdl/dpd_pkg.sv -----
// Shared constants, item types and codes of the delimited packet deframer.
package dpd_pkg;

	// Store size and the address width that follows from it.
	localparam int PACKET_DEPTH = 128;
	localparam int ADDR_W = $clog2(PACKET_DEPTH);

	// Entries of the queue between the front and back parts.
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

	// Item kinds.
	localparam logic [1:0] KIND_RX        = 2'd0;
	localparam logic [1:0] KIND_CLR_PKT   = 2'd1;
	localparam logic [1:0] KIND_CLR_BYTE  = 2'd2;
	localparam logic [1:0] KIND_READ      = 2'd3;

	// Framing characters.
	localparam logic [7:0] HEADER_CHAR = 8'h40;
	localparam logic [7:0] END_CHAR    = 8'h0D;
	localparam logic [7:0] TERM_CHAR   = 8'h00;

	// Input item.
	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] rx_byte;
		logic [6:0] read_index;
	} req_t;

	// Result item.
	typedef struct packed {
		logic       packet_ready;
		logic       byte_ready;
		logic [7:0] last_byte;
		logic [6:0] packet_length;
		logic [7:0] read_data;
		logic       overflow;
	} rsp_t;

	// Queue entry: a state snapshot plus raw store data and its select.
	typedef struct packed {
		logic       packet_ready;
		logic       byte_ready;
		logic [7:0] last_byte;
		logic [6:0] packet_length;
		logic       read_sel;
		logic [7:0] ram_data;
		logic       overflow;
	} entry_t;

endpackage

// ----- hdl/dpd_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
module dpd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Read port; the data holds until the next read.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ----- hdl/dpd_front.sv -----
// Front part: accepts items, runs the framing state and the packet store.
module dpd_front import dpd_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   req_valid,
	output logic   req_stall,
	input  req_t   req,
	output logic   ent_valid,
	input  logic   ent_ready,
	output entry_t ent
);

	localparam logic [ADDR_W-1:0] WP_LAST = ADDR_W'(PACKET_DEPTH - 1);

	logic              receiving_q, receiving_d;
	logic [ADDR_W-1:0] wp_q, wp_d;
	logic              pkt_flag_q, pkt_flag_d;
	logic              byte_flag_q, byte_flag_d;
	logic [7:0]        held_q, held_d;
	logic              ovf_q, ovf_d;

	logic              accept;
	logic              ram_we;
	logic [7:0]        ram_wdata;
	logic              ram_re;
	logic [7:0]        ram_rdata;

	logic              valid_s1;
	logic              pr_s1;
	logic              br_s1;
	logic [7:0]        held_s1;
	logic [6:0]        len_s1;
	logic              sel_s1;
	logic              ovf_s1;

	// The stage holds its item until the queue has room.
	assign req_stall = valid_s1 && !ent_ready;
	assign accept    = req_valid && !req_stall;

	// Framing state update for the accepted item.
	always_comb begin
		receiving_d = receiving_q;
		wp_d        = wp_q;
		pkt_flag_d  = pkt_flag_q;
		byte_flag_d = byte_flag_q;
		held_d      = held_q;
		ovf_d       = ovf_q;
		ram_we      = 1'b0;
		ram_wdata   = req.rx_byte;
		if (accept) begin
			case (req.kind)
				KIND_RX: begin
					held_d      = req.rx_byte;
					byte_flag_d = 1'b1;
					if (!receiving_q) begin
						// A header opens a packet only once the last one was taken.
						if (req.rx_byte == HEADER_CHAR && !pkt_flag_q) begin
							receiving_d = 1'b1;
							wp_d        = '0;
						end
					end else if (req.rx_byte == END_CHAR) begin
						receiving_d = 1'b0;
						ram_we      = 1'b1;
						ram_wdata   = TERM_CHAR;
						pkt_flag_d  = 1'b1;
					end else if (wp_q != WP_LAST) begin
						ram_we = 1'b1;
						wp_d   = wp_q + ADDR_W'(1);
					end else begin
						// The last entry is kept for the terminator.
						ovf_d = 1'b1;
					end
				end
				KIND_CLR_PKT:  pkt_flag_d = 1'b0;
				KIND_CLR_BYTE: byte_flag_d = 1'b0;
				KIND_READ: ;
				default: ;
			endcase
		end
	end

	// A store read is issued only for indexes inside the store.
	assign ram_re = accept && req.kind == KIND_READ && 32'(req.read_index) < PACKET_DEPTH;

	dpd_ram #(
		.WIDTH(8),
		.DEPTH(PACKET_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (wp_q),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ADDR_W'(req.read_index)),
		.rdata (ram_rdata)
	);

	// Framing state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			receiving_q <= 1'b0;
			wp_q        <= '0;
			pkt_flag_q  <= 1'b0;
			byte_flag_q <= 1'b0;
			held_q      <= '0;
			ovf_q       <= 1'b0;
		end else begin
			receiving_q <= receiving_d;
			wp_q        <= wp_d;
			pkt_flag_q  <= pkt_flag_d;
			byte_flag_q <= byte_flag_d;
			held_q      <= held_d;
			ovf_q       <= ovf_d;
		end
	end

	// Stage valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (ent_ready) begin
			valid_s1 <= 1'b0;
		end
	end

	// Snapshot: flags show the value before any clear by this item.
	always_ff @(posedge clk) begin
		if (accept) begin
			pr_s1   <= (req.kind == KIND_RX) ? pkt_flag_d : pkt_flag_q;
			br_s1   <= (req.kind == KIND_RX) ? byte_flag_d : byte_flag_q;
			held_s1 <= held_d;
			len_s1  <= 7'(wp_d);
			sel_s1  <= ram_re;
			ovf_s1  <= ovf_d;
		end
	end

	assign ent_valid         = valid_s1;
	assign ent.packet_ready  = pr_s1;
	assign ent.byte_ready    = br_s1;
	assign ent.last_byte     = held_s1;
	assign ent.packet_length = len_s1;
	assign ent.read_sel      = sel_s1;
	assign ent.ram_data      = ram_rdata;
	assign ent.overflow      = ovf_s1;

endmodule

// ----- hdl/dpd_queue.sv -----
// Short queue that decouples the front part from the back part.
module dpd_queue import dpd_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push_valid,
	output logic   push_ready,
	input  entry_t push_data,
	output logic   pop_valid,
	input  logic   pop_ready,
	output entry_t pop_data
);

	localparam logic [QPTR_W-1:0] PTR_LAST = QPTR_W'(QUEUE_DEPTH - 1);

	entry_t            slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              push;
	logic              pop;

	// Room is judged on the stored count alone.
	assign push_ready = count_q != QCNT_W'(QUEUE_DEPTH);
	assign pop_valid  = count_q != '0;
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_data   = slot_q[rd_ptr_q];

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + QPTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + QCNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - QCNT_W'(1);
			end
		end
	end

endmodule

// ----- hdl/dpd_back.sv -----
// Back part: forms the result item and holds it in the output register.
module dpd_back import dpd_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   ent_valid,
	output logic   ent_ready,
	input  entry_t ent,
	output logic   rsp_valid,
	input  logic   rsp_stall,
	output rsp_t   rsp
);

	logic rsp_valid_q;
	rsp_t rsp_q;
	logic take;

	// The register loads when empty or when its item leaves this cycle.
	assign ent_ready = !rsp_valid_q || !rsp_stall;
	assign take      = ent_valid && ent_ready;

	// Output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (ent_ready) begin
			rsp_valid_q <= ent_valid;
		end
	end

	// Output payload; store data shows only for in-range reads.
	always_ff @(posedge clk) begin
		if (take) begin
			rsp_q.packet_ready  <= ent.packet_ready;
			rsp_q.byte_ready    <= ent.byte_ready;
			rsp_q.last_byte     <= ent.last_byte;
			rsp_q.packet_length <= ent.packet_length;
			rsp_q.read_data     <= ent.read_sel ? ent.ram_data : 8'h00;
			rsp_q.overflow      <= ent.overflow;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

// ----- hdl/delimited_packet_deframer_top.sv -----
// Top level of the delimited packet deframer.
//
//   Channel  Handshake             Payload  Role
//   req      req_valid/req_stall   req_t    received bytes and host accesses
//   rsp      rsp_valid/rsp_stall   rsp_t    one result per item
//
// One item is accepted per cycle when the output side keeps up.
// Each accepted item passes the store read stage and then the queue before
// the output register loads its result.
// Reset clears the framing state, flags and queue; the store is not cleared.
// A stall on rsp fills the two-entry queue before req stalls.
module delimited_packet_deframer_top import dpd_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	logic   f_valid;
	logic   f_ready;
	entry_t f_ent;
	logic   b_valid;
	logic   b_ready;
	entry_t b_ent;

	// Framing and store.
	dpd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.ent_valid (f_valid),
		.ent_ready (f_ready),
		.ent       (f_ent)
	);

	// Decoupling queue.
	dpd_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (f_valid),
		.push_ready (f_ready),
		.push_data  (f_ent),
		.pop_valid  (b_valid),
		.pop_ready  (b_ready),
		.pop_data   (b_ent)
	);

	// Result forming and output register.
	dpd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.ent_valid (b_valid),
		.ent_ready (b_ready),
		.ent       (b_ent),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

endmodule

// ----- hdl/dpd_checker.sv -----
// Port-level checks of the deframer and their binding to the top level.
`include "delimited_packet_deframer_top_defines.svh"

module dpd_checker import dpd_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_stall,
	input req_t req,
	input logic rsp_valid,
	input logic rsp_stall,
	input rsp_t rsp
);

	// Stage, queue and output register together hold at most four items.
	localparam logic [2:0] MAX_INFLIGHT = 3'd4;

	logic       req_acc;
	logic       rsp_acc;
	logic [2:0] inflight_q;
	logic       seen_ovf_q;

	assign req_acc = req_valid && !req_stall;
	assign rsp_acc = rsp_valid && !rsp_stall;

	// Items accepted but not yet answered, and a sticky record of overflow.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_q <= '0;
			seen_ovf_q <= 1'b0;
		end else begin
			inflight_q <= inflight_q + 3'(req_acc) - 3'(rsp_acc);
			if (rsp_acc && rsp.overflow) begin
				seen_ovf_q <= 1'b1;
			end
		end
	end

	`DPD_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp))
	`DPD_ASSERT(a_no_extra_rsp, !rsp_valid || inflight_q != 3'd0)
	`DPD_ASSERT(a_inflight_bound, inflight_q <= MAX_INFLIGHT)
	`DPD_ASSERT(a_ovf_sticky, !(rsp_valid && seen_ovf_q) || rsp.overflow)

endmodule

bind delimited_packet_deframer_top dpd_checker u_checker (.*);
